// ===== design/cre_pkg.sv =====
// Shared types and constants of the chord run extractor.
package cre_pkg;

  localparam int LEN_W = 6;
  localparam int OFS_W = 6;
  localparam int CFG_W = 6;
  localparam int IDX_W = 2;

  typedef enum logic [1:0] {
    KIND_CHORD  = 2'd0,
    KIND_TABLE  = 2'd1,
    KIND_BOUNDS = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEPTH  = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RST = 6'd3;

  localparam logic signed [OFS_W-1:0] BOUND_MIN_RST = 6'sb011111;
  localparam logic signed [OFS_W-1:0] BOUND_MAX_RST = 6'sb100000;

  typedef logic signed [OFS_W-1:0] ofs_t;
  typedef logic [LEN_W-1:0]        len_t;

  // One queued command: an optional chord, an optional end of element
  typedef struct packed {
    logic has_chord;
    logic finish;
    logic any_chord;
    ofs_t ox;
    ofs_t oy;
    ofs_t oz;
    len_t len;
    ofs_t min_x;
    ofs_t max_x;
    ofs_t min_y;
    ofs_t max_y;
    ofs_t min_z;
    ofs_t max_z;
  } cmd_t;

endpackage

// ===== design/cre_front.sv =====
// Front end: pixel counters, run tracking, bounding box and length bitmap.
module cre_front #(
  parameter int MAX_DIM = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [cre_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cre_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  logic                        pixel_on,
  input  logic                        queue_full,
  output logic                        push,
  output cre_pkg::cmd_t               push_cmd,
  output logic [MAX_DIM-1:0]          push_seen
);
  import cre_pkg::*;

  localparam int CW = $clog2(MAX_DIM);

  logic [CFG_W-1:0] image_width, image_height, image_depth;
  logic [CFG_W-1:0] w, h, d, cx, cy, cz;
  logic [CW-1:0]    col_count, row_count, slice_count;
  logic             run_active;
  logic [CW-1:0]    run_start, start_eff;
  ofs_t             bound_min_x, bound_max_x, bound_min_y, bound_max_y;
  ofs_t             bound_min_z, bound_max_z;
  ofs_t             min_x_upd, max_x_upd, min_y_upd, max_y_upd, min_z_upd, max_z_upd;
  logic             any_chord;
  logic [MAX_DIM-1:0] lengths_seen, seen_upd;
  logic [CFG_W-1:0] col_p1, row_p1, slice_p1;
  logic             row_end, slice_end, elem_end;
  logic             chord_a, chord_b, chord, accept;
  len_t             chord_len;
  ofs_t             ox, oy, oz;
  logic [CW-1:0]    seen_idx;

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > CFG_W'(MAX_DIM)) r = CFG_W'(MAX_DIM);
    return r;
  endfunction

  // Hold the dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RST;
      image_height <= DIM_RST;
      image_depth  <= DIM_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        REG_DEPTH:  image_depth  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w  = eff_dim(image_width);
  assign h  = eff_dim(image_height);
  assign d  = eff_dim(image_depth);
  assign cx = (w - CFG_W'(1)) >> 1;
  assign cy = (h - CFG_W'(1)) >> 1;
  assign cz = (d - CFG_W'(1)) >> 1;

  assign pixel_ready = !queue_full;
  assign accept      = pixel_valid && pixel_ready;

  // Classify the pixel: end of run, end of row, end of element
  assign col_p1    = CFG_W'(col_count) + CFG_W'(1);
  assign row_p1    = CFG_W'(row_count) + CFG_W'(1);
  assign slice_p1  = CFG_W'(slice_count) + CFG_W'(1);
  assign row_end   = col_p1 >= w;
  assign slice_end = row_p1 >= h;
  assign elem_end  = row_end && slice_end && (slice_p1 >= d);

  assign start_eff = run_active ? run_start : col_count;
  assign chord_a   = !pixel_on && run_active;
  assign chord_b   = pixel_on && row_end;
  assign chord     = chord_a || chord_b;
  assign chord_len = chord_a ? (CFG_W'(col_count) - CFG_W'(run_start))
                             : (col_p1 - CFG_W'(start_eff));

  assign ox = $signed(CFG_W'(start_eff) - cx);
  assign oy = $signed(CFG_W'(row_count) - cy);
  assign oz = $signed(CFG_W'(slice_count) - cz);

  // Fold the chord into the bounding box and the bitmap
  assign min_x_upd = (chord && ox < bound_min_x) ? ox : bound_min_x;
  assign max_x_upd = (chord && ox > bound_max_x) ? ox : bound_max_x;
  assign min_y_upd = (chord && oy < bound_min_y) ? oy : bound_min_y;
  assign max_y_upd = (chord && oy > bound_max_y) ? oy : bound_max_y;
  assign min_z_upd = (chord && oz < bound_min_z) ? oz : bound_min_z;
  assign max_z_upd = (chord && oz > bound_max_z) ? oz : bound_max_z;

  assign seen_idx = CW'(chord_len - LEN_W'(1));

  always_comb begin
    seen_upd = lengths_seen;
    if (chord) seen_upd[seen_idx] = 1'b1;
  end

  // Queue a command for every pixel that causes results
  assign push                = accept && (chord || elem_end);
  assign push_cmd.has_chord  = chord;
  assign push_cmd.finish     = elem_end;
  assign push_cmd.any_chord  = any_chord || chord;
  assign push_cmd.ox         = ox;
  assign push_cmd.oy         = oy;
  assign push_cmd.oz         = oz;
  assign push_cmd.len        = chord_len;
  assign push_cmd.min_x      = min_x_upd;
  assign push_cmd.max_x      = max_x_upd;
  assign push_cmd.min_y      = min_y_upd;
  assign push_cmd.max_y      = max_y_upd;
  assign push_cmd.min_z      = min_z_upd;
  assign push_cmd.max_z      = max_z_upd;
  assign push_seen           = seen_upd;

  // Advance counters and element state; clear at element end
  always_ff @(posedge clk) begin
    if (rst || (accept && elem_end)) begin
      col_count    <= '0;
      row_count    <= '0;
      slice_count  <= '0;
      run_active   <= 1'b0;
      run_start    <= '0;
      bound_min_x  <= BOUND_MIN_RST;
      bound_max_x  <= BOUND_MAX_RST;
      bound_min_y  <= BOUND_MIN_RST;
      bound_max_y  <= BOUND_MAX_RST;
      bound_min_z  <= BOUND_MIN_RST;
      bound_max_z  <= BOUND_MAX_RST;
      any_chord    <= 1'b0;
      lengths_seen <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_count <= '0;
        if (slice_end) begin
          row_count   <= '0;
          slice_count <= slice_count + CW'(1);
        end else begin
          row_count <= row_count + CW'(1);
        end
      end else begin
        col_count <= col_count + CW'(1);
      end
      run_active   <= pixel_on && !row_end;
      if (pixel_on && !run_active) run_start <= col_count;
      bound_min_x  <= min_x_upd;
      bound_max_x  <= max_x_upd;
      bound_min_y  <= min_y_upd;
      bound_max_y  <= max_y_upd;
      bound_min_z  <= min_z_upd;
      bound_max_z  <= max_z_upd;
      any_chord    <= any_chord || chord;
      lengths_seen <= seen_upd;
    end
  end

endmodule

// ===== design/cre_queue.sv =====
// Command queue between front end and back end.
module cre_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         not_empty,
  output logic         full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;

  assign rdata     = entries[rd_ptr];
  assign not_empty = count != '0;
  assign full      = count == NW'(DEPTH);

  // Store entries
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + NW'(1);
      else if (pop && !push) count <= count - NW'(1);
    end
  end

endmodule

// ===== design/cre_back.sv =====
// Back end: emits chords, bounds or empty markers and the length table into the result register.
module cre_back #(
  parameter int MAX_DIM = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  cre_pkg::cmd_t                      q_cmd,
  input  logic [MAX_DIM-1:0]                 q_seen,
  output logic                               q_pop,
  output logic                               result_valid,
  input  logic                               result_ready,
  output cre_pkg::kind_t                     kind,
  output logic signed [cre_pkg::OFS_W-1:0]   offset_x,
  output logic signed [cre_pkg::OFS_W-1:0]   offset_y,
  output logic signed [cre_pkg::OFS_W-1:0]   offset_z,
  output logic [cre_pkg::LEN_W-1:0]          length,
  output logic signed [cre_pkg::OFS_W-1:0]   min_x,
  output logic signed [cre_pkg::OFS_W-1:0]   max_x,
  output logic signed [cre_pkg::OFS_W-1:0]   min_y,
  output logic signed [cre_pkg::OFS_W-1:0]   max_y,
  output logic signed [cre_pkg::OFS_W-1:0]   min_z,
  output logic signed [cre_pkg::OFS_W-1:0]   max_z,
  output logic                               last
);
  import cre_pkg::*;

  localparam int CW = $clog2(MAX_DIM);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHORD  = 5'b00010,
    ST_FINISH = 5'b00100,
    ST_ONE    = 5'b01000,
    ST_WALK   = 5'b10000
  } state_t;

  state_t             state, state_next;
  cmd_t               cmd;
  logic [MAX_DIM-1:0] seen;
  len_t               val, val_next;
  logic [CW-1:0]      idx, idx_next;
  logic               load_out, above;
  logic [LEN_W:0]     dbl;
  len_t               cur_len;
  logic               emit, e_last;
  kind_t              e_kind;
  ofs_t               e_ox, e_oy, e_oz;
  ofs_t               e_min_x, e_max_x, e_min_y, e_max_y, e_min_z, e_max_z;
  len_t               e_len;

  assign load_out = !result_valid || result_ready;
  assign cur_len  = LEN_W'(idx) + LEN_W'(1);
  assign dbl      = {val, 1'b0};

  // Any length seen above the current index
  always_comb begin
    above = 1'b0;
    for (int i = 0; i < MAX_DIM; i++) begin
      if (seen[i] && (CW'(i) > idx)) above = 1'b1;
    end
  end

  // Sequence the results of one command
  always_comb begin
    state_next = state;
    val_next   = val;
    idx_next   = idx;
    q_pop      = 1'b0;
    emit       = 1'b0;
    e_kind     = KIND_CHORD;
    e_last     = 1'b0;
    e_ox       = '0;
    e_oy       = '0;
    e_oz       = '0;
    e_len      = '0;
    e_min_x    = '0;
    e_max_x    = '0;
    e_min_y    = '0;
    e_max_y    = '0;
    e_min_z    = '0;
    e_max_z    = '0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          idx_next   = '0;
          state_next = q_cmd.has_chord ? ST_CHORD : ST_FINISH;
        end
      end
      ST_CHORD: begin
        if (load_out) begin
          emit       = 1'b1;
          e_kind     = KIND_CHORD;
          e_ox       = cmd.ox;
          e_oy       = cmd.oy;
          e_oz       = cmd.oz;
          e_len      = cmd.len;
          state_next = cmd.finish ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          emit = 1'b1;
          if (!cmd.any_chord) begin
            e_kind     = KIND_EMPTY;
            e_last     = 1'b1;
            state_next = ST_IDLE;
          end else begin
            e_kind     = KIND_BOUNDS;
            e_min_x    = cmd.min_x;
            e_max_x    = cmd.max_x;
            e_min_y    = cmd.min_y;
            e_max_y    = cmd.max_y;
            e_min_z    = cmd.min_z;
            e_max_z    = cmd.max_z;
            state_next = ST_ONE;
          end
        end
      end
      ST_ONE: begin
        if (load_out) begin
          emit       = 1'b1;
          e_kind     = KIND_TABLE;
          e_len      = LEN_W'(1);
          e_last     = !above;
          val_next   = LEN_W'(1);
          idx_next   = CW'(1);
          state_next = above ? ST_WALK : ST_IDLE;
        end
      end
      ST_WALK: begin
        if (!seen[idx]) begin
          idx_next = idx + CW'(1);
        end else if (load_out) begin
          emit   = 1'b1;
          e_kind = KIND_TABLE;
          if (dbl < {1'b0, cur_len}) begin
            // insert a doubling, stay on this length
            e_len    = dbl[LEN_W-1:0];
            val_next = dbl[LEN_W-1:0];
          end else begin
            e_len      = cur_len;
            e_last     = !above;
            val_next   = cur_len;
            idx_next   = idx + CW'(1);
            state_next = above ? ST_WALK : ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the current command
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd  <= q_cmd;
      seen <= q_seen;
    end
    val <= val_next;
    idx <= idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst)               result_valid <= 1'b0;
    else if (emit)         result_valid <= 1'b1;
    else if (result_ready) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind     <= e_kind;
      offset_x <= e_ox;
      offset_y <= e_oy;
      offset_z <= e_oz;
      length   <= e_len;
      min_x    <= e_min_x;
      max_x    <= e_max_x;
      min_y    <= e_min_y;
      max_y    <= e_max_y;
      min_z    <= e_min_z;
      max_z    <= e_max_z;
      last     <= e_last;
    end
  end

endmodule

// ===== design/chord_run_extractor_unit.sv =====
// Top level of the chord run extractor: front end, command queue, back end.
//
//   channel   direction  handshake                  payload
//   config    in         cfg_write                  cfg_index, cfg_data
//   pixel     in         pixel_valid / pixel_ready  pixel_on
//   result    out        result_valid / result_ready kind .. last
//
// One pixel is taken per cycle while the two-entry command queue has room.
// Each command is loaded from the queue before its results go to the result register;
// the length table walk steps through the seen lengths in turn, inserting doublings
// and waiting while the result register is still held.
// Reset is synchronous; result_ready low fills the queue, then drops pixel_ready.
module chord_run_extractor_unit #(
  parameter int MAX_DIM = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [cre_pkg::IDX_W-1:0]          cfg_index,
  input  logic [cre_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  logic                               pixel_on,
  output logic                               result_valid,
  input  logic                               result_ready,
  output cre_pkg::kind_t                     kind,
  output logic signed [cre_pkg::OFS_W-1:0]   offset_x,
  output logic signed [cre_pkg::OFS_W-1:0]   offset_y,
  output logic signed [cre_pkg::OFS_W-1:0]   offset_z,
  output logic [cre_pkg::LEN_W-1:0]          length,
  output logic signed [cre_pkg::OFS_W-1:0]   min_x,
  output logic signed [cre_pkg::OFS_W-1:0]   max_x,
  output logic signed [cre_pkg::OFS_W-1:0]   min_y,
  output logic signed [cre_pkg::OFS_W-1:0]   max_y,
  output logic signed [cre_pkg::OFS_W-1:0]   min_z,
  output logic signed [cre_pkg::OFS_W-1:0]   max_z,
  output logic                               last
);
  import cre_pkg::*;

  localparam int QW     = $bits(cmd_t) + MAX_DIM;
  localparam int QDEPTH = 2;

  logic               push, pop, q_full, q_valid;
  cmd_t               push_cmd, q_cmd;
  logic [MAX_DIM-1:0] push_seen, q_seen;
  logic [QW-1:0]      q_wdata, q_rdata;

  cre_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_on    (pixel_on),
    .queue_full  (q_full),
    .push        (push),
    .push_cmd    (push_cmd),
    .push_seen   (push_seen)
  );

  // Pack command and bitmap into one queue word
  assign q_wdata         = {push_seen, push_cmd};
  assign q_seen          = q_rdata[QW-1 -: MAX_DIM];
  assign q_cmd           = q_rdata[$bits(cmd_t)-1:0];

  cre_queue #(.W(QW), .DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (q_wdata),
    .pop       (pop),
    .rdata     (q_rdata),
    .not_empty (q_valid),
    .full      (q_full)
  );

  cre_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_seen       (q_seen),
    .q_pop        (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .offset_z     (offset_z),
    .length       (length),
    .min_x        (min_x),
    .max_x        (max_x),
    .min_y        (min_y),
    .max_y        (max_y),
    .min_z        (min_z),
    .max_z        (max_z),
    .last         (last)
  );

endmodule
